/* src/srq_pkg.sv */
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants of the sequence reorder queue
// Widths, status codes and the command beat passed from front to back.
// ----------------------------------------------------------------------------
package srq_pkg;

	localparam int unsigned DEPTH   = 256;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned CW      = $clog2(DEPTH + 1);
	localparam int unsigned SEQ_W   = 31;
	localparam int unsigned HND_W   = 8;
	localparam int unsigned ST_W    = 3;
	localparam int unsigned QDEPTH  = 2;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_POPPED    = 3'd3,
		ST_MISS      = 3'd4
	} status_t;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SEQ_W-1:0] seq;
		logic [HND_W-1:0] hnd;
	} cmd_t;

endpackage

/* src/srq_ram.sv */
// ----------------------------------------------------------------------------
// srq_ram: generic single-port RAM with registered read
// One access per cycle: write, or read with the data registered for the next cycle.
// ----------------------------------------------------------------------------
module srq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* src/srq_front.sv */
// ----------------------------------------------------------------------------
// srq_front: command intake and queue
// Takes start beats and holds them in a short FIFO for the back end.
// ----------------------------------------------------------------------------
module srq_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     operation,
	input  logic [srq_pkg::SEQ_W-1:0] sequence_req,
	input  logic [srq_pkg::HND_W-1:0] handle,
	output logic                     busy,
	output logic                     cmd_valid,
	output srq_pkg::cmd_t            cmd,
	input  logic                     cmd_take
);

	localparam int unsigned PW = $clog2(srq_pkg::QDEPTH);

	srq_pkg::cmd_t     fifo_q [srq_pkg::QDEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;
	logic              push;

	assign busy      = (cnt_q == (PW+1)'(srq_pkg::QDEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{op: srq_pkg::op_t'(operation), seq: sequence_req, hnd: handle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_take) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(cmd_take);
		end
	end

endmodule

/* src/srq_back.sv */
// ----------------------------------------------------------------------------
// srq_back: sorted table engine
// Walks the sorted table in RAM, shifts entries for insert and pop, reports.
// ----------------------------------------------------------------------------
module srq_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  srq_pkg::cmd_t             cmd,
	output logic                      cmd_take,
	output logic                      done,
	output logic [srq_pkg::ST_W-1:0]  status,
	output logic [srq_pkg::HND_W-1:0] handle_out,
	output logic [8:0]                occupancy
);

	localparam int unsigned AW = srq_pkg::AW;
	localparam int unsigned CW = srq_pkg::CW;
	localparam int unsigned EW = srq_pkg::SEQ_W + srq_pkg::HND_W;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_SHRD, S_SHWR, S_PUT, S_DONE
	} state_t;

	state_t                    state_q;
	srq_pkg::cmd_t             cmd_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             pos_q;
	logic [CW-1:0]             idx_q;
	logic [srq_pkg::ST_W-1:0]  st_q;
	logic [srq_pkg::HND_W-1:0] hout_q;

	logic                      we;
	logic [AW-1:0]             addr;
	logic [EW-1:0]             wdata;
	logic [EW-1:0]             rdata;
	logic [srq_pkg::SEQ_W-1:0] rseq;
	logic [CW-1:0]             idx_dec;

	assign rseq    = rdata[EW-1 -: srq_pkg::SEQ_W];
	assign idx_dec = idx_q - 1'b1;

	srq_ram #(.WIDTH(EW), .DEPTH(srq_pkg::DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	// insert moves entry idx-1 up to idx; pop moves entry idx down to idx-1
	always_comb begin
		we    = 1'b0;
		addr  = idx_q[AW-1:0];
		wdata = rdata;
		unique case (state_q)
			S_SHRD: begin
				if (cmd_q.op == srq_pkg::OP_ENQ) begin
					addr = idx_dec[AW-1:0];
				end
			end
			S_SHWR: begin
				we = 1'b1;
				if (cmd_q.op == srq_pkg::OP_DEQ) begin
					addr = idx_dec[AW-1:0];
				end
			end
			S_PUT: begin
				we    = 1'b1;
				wdata = {cmd_q.seq, cmd_q.hnd};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			st_q       <= '0;
			hout_q     <= '0;
			done       <= 1'b0;
			status     <= '0;
			handle_out <= '0;
			occupancy  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						pos_q   <= '0;
						idx_q   <= '0;
						hout_q  <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (cmd_q.op == srq_pkg::OP_DEQ) begin
						if (count_q == '0) begin
							st_q    <= srq_pkg::ST_MISS;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CMP;
						end
					end else if (pos_q == count_q) begin
						if (count_q == CW'(srq_pkg::DEPTH)) begin
							st_q    <= srq_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							idx_q   <= count_q;
							state_q <= S_SHRD;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cmd_q.op == srq_pkg::OP_DEQ) begin
						if (rseq != cmd_q.seq) begin
							st_q    <= srq_pkg::ST_MISS;
							state_q <= S_DONE;
						end else begin
							hout_q  <= rdata[srq_pkg::HND_W-1:0];
							st_q    <= srq_pkg::ST_POPPED;
							count_q <= count_q - 1'b1;
							idx_q   <= CW'(1);
							pos_q   <= '0;
							state_q <= S_SHRD;
						end
					end else if (rseq == cmd_q.seq) begin
						st_q    <= srq_pkg::ST_DUPLICATE;
						state_q <= S_DONE;
					end else if (cmd_q.seq < rseq) begin
						if (count_q == CW'(srq_pkg::DEPTH)) begin
							st_q    <= srq_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							idx_q   <= count_q;
							state_q <= S_SHRD;
						end
					end else begin
						pos_q   <= pos_q + 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_SHRD: begin
					if (cmd_q.op == srq_pkg::OP_DEQ) begin
						if (idx_q > count_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SHWR;
						end
					end else if (idx_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					if (cmd_q.op == srq_pkg::OP_DEQ) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						idx_q <= idx_dec;
					end
					state_q <= S_SHRD;
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
					st_q    <= srq_pkg::ST_INSERTED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done       <= 1'b1;
					status     <= st_q;
					handle_out <= hout_q;
					occupancy  <= 9'(count_q);
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/sequence_reorder_queue_top.sv */
// ----------------------------------------------------------------------------
// sequence_reorder_queue_top: sorted reorder queue of sequence/handle entries
//
// Command channel: a beat is taken when start is high and busy is low.
// operation 0 inserts sequence_req with handle in ascending order, rejecting
// duplicates and reporting a full table; operation 1 pops the head only if
// it equals sequence_req.
// Result channel: done pulses for one cycle with status, handle_out and
// occupancy. The receiver cannot stall; each command gives one result.
// A two-entry command queue decouples intake from the table engine, so busy
// rises only when both entries hold unprocessed commands.
// Table work uses the single-port table RAM: an insert walks the entries below
// the insert point with a read and a compare state each, then shifts each
// entry from the insert point up with a read and a write state; a pop shifts
// each remaining entry down the same way. One command is in work at a time.
// Reset clears the count; table contents need no clearing.
// ----------------------------------------------------------------------------
module sequence_reorder_queue_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      operation,
	input  logic [srq_pkg::SEQ_W-1:0] sequence_req,
	input  logic [srq_pkg::HND_W-1:0] handle,
	output logic                      done,
	output logic [srq_pkg::ST_W-1:0]  status,
	output logic [srq_pkg::HND_W-1:0] handle_out,
	output logic [8:0]                occupancy
);

	logic          cmd_valid;
	logic          cmd_take;
	srq_pkg::cmd_t cmd;

	srq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.sequence_req (sequence_req),
		.handle       (handle),
		.busy         (busy),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	srq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.done       (done),
		.status     (status),
		.handle_out (handle_out),
		.occupancy  (occupancy)
	);

endmodule
